@@ hw/rtl/fd_pkg.sv @@
`default_nettype none

package fd_pkg;

    // field and counter widths
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 33;
    localparam int SUM_W      = CNT_W + 1;
    localparam int PCT_W      = 7;
    localparam int THR_W      = 7;
    localparam int NUM_W      = CNT_W + 7;
    localparam int PCT_ITERS  = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_EN = 2'd2;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 7'd30;

    // decay window in seconds, default
    localparam int DECAY_INTERVAL_DEF = 30 * 60;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_MUL_POS,
        ST_RCP_POS,
        ST_MUL_NEG,
        ST_RCP_NEG,
        ST_ADD,
        ST_PCT,
        ST_START_PCT,
        ST_WAIT_PCT,
        ST_EMIT
    } fd_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic sum_ld;
        logic clear;
        logic mul_ld;
        logic mul_neg;
        logic div_start;
        logic wr_pos;
        logic wr_neg;
        logic add;
        logic pct_ld;
        logic emit;
    } fd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sum_gt_i;
        logic sum_ge_2i;
        logic sum_zero;
        logic div_busy;
        logic div_done;
        logic out_free;
    } fd_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/fd_div.sv @@
`default_nettype none

module fd_div #(
    parameter int NW = 40,
    parameter int DW = 34,
    parameter int QW = 12,
    localparam int IW = $clog2(QW + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [IW-1:0] iters,
    input  wire logic [DW-1:0] rem_init,
    input  wire logic [NW-1:0] bits_init,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic               done,
    output logic [QW-1:0]      quot,
    output logic [DW-1:0]      rem
);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [NW-1:0] bits_reg, bits_next;
    logic [QW-1:0] quot_reg, quot_next;

    logic [DW:0]   trial;
    logic [DW:0]   trial_sub;
    logic          ge;
    logic [DW-1:0] rem_step;

    // one restoring step: bring down the next bit, subtract if it fits
    always_comb begin
        trial     = {rem_reg, bits_reg[NW-1]};
        trial_sub = trial - {1'b0, den_reg};
        ge        = trial >= {1'b0, den_reg};
        rem_step  = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
    end

    // iteration control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = iters;
            rem_next  = rem_init;
            den_next  = den;
            bits_next = bits_init;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = rem_step;
            bits_next = bits_reg << 1;
            quot_next = {quot_reg[QW-2:0], ge};
            cnt_next  = cnt_reg - IW'(1);
            if (cnt_reg == IW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fd_datapath.sv @@
`default_nettype none

module fd_datapath #(
    parameter int DECAY_INTERVAL = fd_pkg::DECAY_INTERVAL_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [fd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [fd_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [fd_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                 m_tuser,
    input  wire fd_pkg::fd_cmd_t                 cmd,
    output fd_pkg::fd_status_t                   status
);

    localparam int CW  = fd_pkg::CNT_W;
    localparam int SW  = fd_pkg::SUM_W;
    localparam int NW  = fd_pkg::NUM_W;
    localparam int PW  = fd_pkg::PCT_W;
    localparam int TW  = fd_pkg::TIME_W;
    // counters below twice the window fit in DKW bits, the decay factor in FW
    localparam int DKW = $clog2(2 * DECAY_INTERVAL);
    localparam int FW  = $clog2(DECAY_INTERVAL + 1);
    localparam int QW  = fd_pkg::PCT_ITERS;
    localparam int IW  = $clog2(QW + 1);
    // decay product width, reciprocal shift and reciprocal width
    localparam int PRW = DKW + FW;
    localparam int RK  = PRW + FW;
    localparam int RW  = PRW + 2;

    localparam logic [SW-1:0] INTERVAL     = SW'(DECAY_INTERVAL);
    localparam logic [SW-1:0] TWO_INTERVAL = SW'(2 * DECAY_INTERVAL);

    // ceil(2^RK / window): exact floor division for any product below 2^PRW
    localparam longint RECIP_L = ((longint'(1) << RK) + longint'(DECAY_INTERVAL) - 1) /
                                 longint'(DECAY_INTERVAL);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

    // configuration
    logic [fd_pkg::THR_W-1:0] thr_reg, thr_next;
    logic                     local_en_reg, local_en_next;
    logic                     global_en_reg, global_en_next;

    // check state and working registers
    logic          seen_reg, seen_next;
    logic [TW-1:0] last_reg, last_next;
    logic          chg_reg, chg_next;
    logic [CW-1:0] diff_reg, diff_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] neg_reg, neg_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [NW-1:0] num_reg, num_next;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic          out_flap_reg, out_flap_next;
    logic [PW-1:0] out_pct_reg, out_pct_next;

    logic [DKW-1:0]    mul_a;
    logic [FW-1:0]     factor;
    logic [SW-1:0]     factor_full;
    logic [PRW-1:0]    prod_raw;
    logic [PRW+RW-1:0] rcp_prod;
    logic [DKW-1:0]    dec_q;
    logic [NW-1:0]     pos_ext;
    logic [NW-1:0]     hund;
    logic [CW+1:0]     add_full;
    logic [CW-1:0]     add_sel;
    logic [CW-1:0]     add_res;
    logic [SW-1:0]     cnt_sum;

    logic          div_busy;
    logic          div_done;
    logic [QW-1:0] div_quot;
    logic [SW-1:0] div_rem;
    logic [IW-1:0] div_iters;
    logic [SW-1:0] div_rem_init;
    logic [NW-1:0] div_bits_init;
    logic [SW-1:0] div_den;

    logic          out_free;
    logic [PW-1:0] pct_val;
    logic          flap_val;

    // configuration writes, unknown index ignored
    always_comb begin
        thr_next       = thr_reg;
        local_en_next  = local_en_reg;
        global_en_next = global_en_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                fd_pkg::REG_THRESHOLD: thr_next       = cfg_data;
                fd_pkg::REG_LOCAL_EN:  local_en_next  = cfg_data[0];
                fd_pkg::REG_GLOBAL_EN: global_en_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    // decay product: counter times (2I - S)
    always_comb begin
        factor_full = TWO_INTERVAL - sum_reg;
        factor      = factor_full[FW-1:0];
        mul_a       = cmd.mul_neg ? neg_reg[DKW-1:0] : pos_reg[DKW-1:0];
        prod_raw    = mul_a * factor;
    end

    // decay product over the window by reciprocal multiplication
    always_comb begin
        rcp_prod = num_reg[PRW-1:0] * RECIP;
        dec_q    = rcp_prod[RK+DKW-1:RK];
    end

    // 100 * positive counter as shift and add
    always_comb begin
        pos_ext = {{(NW - CW){1'b0}}, pos_reg};
        hund    = (pos_ext << 6) + (pos_ext << 5) + (pos_ext << 2);
        cnt_sum = {1'b0, pos_reg} + {1'b0, neg_reg};
    end

    // signed elapsed time into the chosen counter, clamped to counter range
    always_comb begin
        add_sel  = chg_reg ? pos_reg : neg_reg;
        add_full = {2'b00, add_sel} + {{2{diff_reg[CW-1]}}, diff_reg};
        if (add_full[CW+1]) begin
            add_res = '0;
        end else if (add_full[CW]) begin
            add_res = '1;
        end else begin
            add_res = add_full[CW-1:0];
        end
    end

    // working register updates
    always_comb begin
        seen_next = seen_reg;
        last_next = last_reg;
        chg_next  = chg_reg;
        diff_next = diff_reg;
        pos_next  = pos_reg;
        neg_next  = neg_reg;
        sum_next  = sum_reg;
        num_next  = num_reg;
        if (cmd.capture) begin
            seen_next = 1'b1;
            last_next = s_tdata[TW-1:0];
            chg_next  = s_tuser;
            diff_next = seen_reg ? ({1'b0, s_tdata[TW-1:0]} - {1'b0, last_reg}) : '0;
        end
        if (cmd.sum_ld) begin
            sum_next = cnt_sum;
        end
        if (cmd.clear) begin
            pos_next = '0;
            neg_next = '0;
        end
        if (cmd.mul_ld) begin
            num_next = NW'(prod_raw);
        end
        if (cmd.pct_ld) begin
            num_next = hund;
        end
        if (cmd.wr_pos) begin
            pos_next = {{(CW - DKW){1'b0}}, dec_q};
        end
        if (cmd.wr_neg) begin
            neg_next = {{(CW - DKW){1'b0}}, dec_q};
        end
        if (cmd.add) begin
            if (chg_reg) begin
                pos_next = add_res;
            end else begin
                neg_next = add_res;
            end
        end
    end

    // divider operands: the percentage fits 7 bits, so start part way in
    always_comb begin
        div_iters     = IW'(fd_pkg::PCT_ITERS);
        div_rem_init  = SW'(num_reg >> fd_pkg::PCT_ITERS);
        div_bits_init = num_reg << (NW - fd_pkg::PCT_ITERS);
        div_den       = sum_reg;
    end

    fd_div #(
        .NW(NW),
        .DW(SW),
        .QW(QW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .iters     (div_iters),
        .rem_init  (div_rem_init),
        .bits_init (div_bits_init),
        .den       (div_den),
        .busy      (div_busy),
        .done      (div_done),
        .quot      (div_quot),
        .rem       (div_rem)
    );

    // percentage and flapping flag from quotient and remainder
    always_comb begin
        if (sum_reg == '0) begin
            pct_val  = '0;
            flap_val = 1'b0;
        end else begin
            pct_val  = div_quot[PW-1:0];
            flap_val = local_en_reg && global_en_reg &&
                       ((pct_val > thr_reg) ||
                        ((pct_val == thr_reg) && (div_rem != '0)));
        end
    end

    // result register
    always_comb begin
        out_free       = !out_valid_reg || m_tready;
        out_valid_next = out_valid_reg;
        out_flap_next  = out_flap_reg;
        out_pct_next   = out_pct_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_flap_next  = flap_val;
            out_pct_next   = pct_val;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= fd_pkg::THRESHOLD_RST;
            local_en_reg  <= 1'b1;
            global_en_reg <= 1'b1;
            seen_reg      <= 1'b0;
            last_reg      <= '0;
            pos_reg       <= '0;
            neg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            thr_reg       <= thr_next;
            local_en_reg  <= local_en_next;
            global_en_reg <= global_en_next;
            seen_reg      <= seen_next;
            last_reg      <= last_next;
            pos_reg       <= pos_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
        chg_reg      <= chg_next;
        diff_reg     <= diff_next;
        sum_reg      <= sum_next;
        num_reg      <= num_next;
        out_flap_reg <= out_flap_next;
        out_pct_reg  <= out_pct_next;
    end

    // status back to the controller
    always_comb begin
        status.sum_gt_i  = sum_reg > INTERVAL;
        status.sum_ge_2i = sum_reg >= TWO_INTERVAL;
        status.sum_zero  = sum_reg == '0;
        status.div_busy  = div_busy;
        status.div_done  = div_done;
        status.out_free  = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(fd_pkg::OUT_DATA_W - PW){1'b0}}, out_pct_reg};
    assign m_tuser  = out_flap_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fd_ctrl.sv @@
`default_nettype none

module fd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire fd_pkg::fd_status_t status,
    output fd_pkg::fd_cmd_t         cmd
);

    fd_pkg::fd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencing of one check beat
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            fd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = fd_pkg::ST_SUM;
                end
            end
            fd_pkg::ST_SUM: begin
                cmd.sum_ld = 1'b1;
                state_next = fd_pkg::ST_CHECK;
            end
            fd_pkg::ST_CHECK: begin
                if (status.sum_ge_2i) begin
                    cmd.clear  = 1'b1;
                    state_next = fd_pkg::ST_ADD;
                end else if (status.sum_gt_i) begin
                    state_next = fd_pkg::ST_MUL_POS;
                end else begin
                    state_next = fd_pkg::ST_ADD;
                end
            end
            fd_pkg::ST_MUL_POS: begin
                cmd.mul_ld = 1'b1;
                state_next = fd_pkg::ST_RCP_POS;
            end
            fd_pkg::ST_RCP_POS: begin
                cmd.wr_pos = 1'b1;
                state_next = fd_pkg::ST_MUL_NEG;
            end
            fd_pkg::ST_MUL_NEG: begin
                cmd.mul_ld  = 1'b1;
                cmd.mul_neg = 1'b1;
                state_next  = fd_pkg::ST_RCP_NEG;
            end
            fd_pkg::ST_RCP_NEG: begin
                cmd.wr_neg = 1'b1;
                state_next = fd_pkg::ST_ADD;
            end
            fd_pkg::ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = fd_pkg::ST_PCT;
            end
            fd_pkg::ST_PCT: begin
                cmd.sum_ld = 1'b1;
                cmd.pct_ld = 1'b1;
                state_next = fd_pkg::ST_START_PCT;
            end
            fd_pkg::ST_START_PCT: begin
                // empty window: no division needed
                if (status.sum_zero) begin
                    state_next = fd_pkg::ST_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = fd_pkg::ST_WAIT_PCT;
                end
            end
            fd_pkg::ST_WAIT_PCT: begin
                if (status.div_done) begin
                    state_next = fd_pkg::ST_EMIT;
                end
            end
            fd_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = fd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fd_pkg::ST_IDLE;
            end
        endcase
    end

    // divider is never restarted while it runs
    a_start_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    // a result is loaded only into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("result loaded over a waiting beat");

    // the sequence leaves idle only on an input beat
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fd_pkg::ST_IDLE && !s_tvalid) |=> state_reg == fd_pkg::ST_IDLE)
        else $error("left idle without input beat");

    // divider completion only seen while waiting for the percentage
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> state_reg == fd_pkg::ST_WAIT_PCT)
        else $error("divider done outside the wait state");

endmodule

`default_nettype wire

@@ hw/rtl/flap_detector_top.sv @@
// Flapping detector over time-weighted change and steady second counters.
//
// Input stream: one beat per check result. s_tdata[31:0] is the check time
// in seconds, s_tuser[0] is set when the checked state changed.
// Output stream: one beat per input beat. m_tdata[6:0] is the change
// percentage, m_tuser[0] is the flapping flag.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 threshold
// percentage, 1 local enable, 2 global enable) at the same edge.
//
// Output valid rises once the beat has passed the sum, check and add steps,
// the percentage load and the 7-step bit-serial percentage divide. A decay
// of the counters adds one multiply and one reciprocal multiply per
// counter; when both counters end at zero the divide is skipped. One item
// is in flight at a time and the next beat is taken in the cycle after its
// result enters the output register, so a ready receiver gets one result
// per input beat.
// Reset restores the registers to threshold 30 with both enables set and
// clears the history. A stalled receiver holds the result in the output
// register; a new beat is still accepted and processed, then waits for it.
`default_nettype none

module flap_detector_top #(
    parameter int DECAY_INTERVAL = fd_pkg::DECAY_INTERVAL_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [fd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fd_pkg::CFG_DATA_W-1:0] cfg_data,
    // input beats
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [fd_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] now_seconds
    input  wire logic                          s_tuser,   // [0] state_change
    // result beats
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [fd_pkg::OUT_DATA_W-1:0]      m_tdata,   // [6:0] change_pct, [7] zero
    output logic                               m_tuser    // [0] flapping
);

    fd_pkg::fd_cmd_t    cmd;
    fd_pkg::fd_status_t status;

    // sequencer
    fd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, divider and result register
    fd_datapath #(
        .DECAY_INTERVAL(DECAY_INTERVAL)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
